/* hw/rtl/fault_set_clear_qualifier_assert.svh */
// Assertion macros shared by the qualifier RTL.
`ifndef FAULT_SET_CLEAR_QUALIFIER_ASSERT_SVH
`define FAULT_SET_CLEAR_QUALIFIER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FSQ_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("fault qualifier: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define FSQ_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("fault qualifier: next-cycle check failed");

`endif

/* hw/rtl/fsq_pkg.sv */
package fsq_pkg;

   localparam int BANK_W  = 1;
   localparam int INDEX_W = 4;
   localparam int DELAY_W = 16;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;    // write a zero entry at the sweep address
      logic capture;  // latch an accepted poll
      logic read;     // read the table entry of the latched poll
      logic update;   // write back the updated entry and issue the result
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;  // sweep address is at the last entry
   } status_type;

endpackage

/* hw/rtl/fsq_ctrl.sv */
module fsq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output fsq_pkg::cmd_type    cmd,
   input  fsq_pkg::status_type status
);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_READ   = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.clear   = 1'b0;
      cmd.capture = 1'b0;
      cmd.read    = 1'b0;
      cmd.update  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/fsq_datapath.sv */
module fsq_datapath #(
   parameter int ENTRIES_PER_BANK = 16,
   parameter int BANK_COUNT       = 2,
   parameter int COUNT_BITS       = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fsq_pkg::cmd_type                cmd,
   output fsq_pkg::status_type             status,
   input  logic [fsq_pkg::BANK_W-1:0]      req_bank,
   input  logic [fsq_pkg::INDEX_W-1:0]     req_fault_index,
   input  logic                            req_func,
   input  logic [fsq_pkg::DELAY_W-1:0]     req_delay_count,
   output logic                            rsp_strobe,
   output logic                            rsp_fault_flag
);

   localparam int DEPTH   = BANK_COUNT * ENTRIES_PER_BANK;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int ENTRY_W = 2 * COUNT_BITS + 1;
   localparam int CMP_W   = (COUNT_BITS > fsq_pkg::DELAY_W) ? COUNT_BITS : fsq_pkg::DELAY_W;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [CMP_W-1:0]      MAX_EXT   = CMP_W'(COUNT_MAX);

   // Entry layout: {flag, clear counter, set counter}
   logic [ENTRY_W-1:0] table_mem [DEPTH];

   logic [ADDR_W-1:0]              clr_addr_ff;
   logic [ADDR_W-1:0]              clr_addr_in;
   logic [ADDR_W-1:0]              addr_ff;
   logic [ADDR_W-1:0]              addr_in;
   logic                           in_range_ff;
   logic                           in_range_in;
   logic                           func_ff;
   logic [fsq_pkg::DELAY_W-1:0]    delay_ff;
   logic [ENTRY_W-1:0]             rd_data_ff;
   logic                           rsp_strobe_ff;
   logic                           rsp_flag_ff;
   logic                           rsp_flag_in;

   logic [COUNT_BITS-1:0] set_cnt;
   logic [COUNT_BITS-1:0] clr_cnt;
   logic                  old_flag;
   logic [COUNT_BITS-1:0] own_cnt;
   logic [COUNT_BITS-1:0] other_cnt;
   logic [COUNT_BITS-1:0] inc_cnt;
   logic [CMP_W-1:0]      delay_ext;
   logic [COUNT_BITS-1:0] clamp_cnt;
   logic                  qualified;
   logic [COUNT_BITS-1:0] new_own;
   logic [COUNT_BITS-1:0] new_other;
   logic                  new_flag;
   logic [ENTRY_W-1:0]    wr_data;
   logic [ADDR_W-1:0]     wr_addr;
   logic                  wr_en;

   function automatic logic [COUNT_BITS-1:0] req_func_sel(
      input logic                  sel,
      input logic [COUNT_BITS-1:0] a,
      input logic [COUNT_BITS-1:0] b
   );
      return sel ? b : a;
   endfunction

   // Decode the poll into a flat table address.
   assign in_range_in = (32'(req_bank) < BANK_COUNT) && (32'(req_fault_index) < ENTRIES_PER_BANK);
   assign addr_in     = ADDR_W'(32'(req_bank) * 32'(ENTRIES_PER_BANK) + 32'(req_fault_index));

   assign clr_addr_in       = clr_addr_ff + ADDR_W'(1);
   assign status.clear_last = (clr_addr_ff == ADDR_W'(DEPTH - 1));

   assign set_cnt  = rd_data_ff[COUNT_BITS-1:0];
   assign clr_cnt  = rd_data_ff[2*COUNT_BITS-1:COUNT_BITS];
   assign old_flag = rd_data_ff[ENTRY_W-1];

   always_comb begin
      own_cnt   = req_func_sel(func_ff, set_cnt, clr_cnt);
      other_cnt = req_func_sel(func_ff, clr_cnt, set_cnt);
   end

   // Saturating count, then qualify against the delay.
   assign inc_cnt   = (own_cnt == COUNT_MAX) ? COUNT_MAX : own_cnt + COUNT_BITS'(1);
   assign delay_ext = CMP_W'(delay_ff);
   assign clamp_cnt = (delay_ext >= MAX_EXT) ? COUNT_MAX : COUNT_BITS'(delay_ext);
   assign qualified = (CMP_W'(inc_cnt) >= delay_ext);
   assign new_own   = qualified ? clamp_cnt : inc_cnt;
   assign new_other = qualified ? '0 : other_cnt;
   // A qualified set attempt raises the flag, a qualified clear attempt drops it.
   assign new_flag  = qualified ? ~func_ff : old_flag;

   always_comb begin
      if (func_ff) begin
         wr_data = {new_flag, new_own, new_other};
      end else begin
         wr_data = {new_flag, new_other, new_own};
      end
      if (cmd.clear) begin
         wr_data = '0;
      end
   end

   assign wr_addr     = cmd.clear ? clr_addr_ff : addr_ff;
   assign wr_en       = cmd.clear || (cmd.update && in_range_ff);
   assign rsp_flag_in = in_range_ff & new_flag;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (cmd.read) begin
         rd_data_ff <= table_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff     <= addr_in;
         in_range_ff <= in_range_in;
         func_ff     <= req_func;
         delay_ff    <= req_delay_count;
      end
      if (cmd.update) begin
         rsp_flag_ff <= rsp_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            clr_addr_ff <= clr_addr_in;
         end
         rsp_strobe_ff <= cmd.update;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_fault_flag = rsp_flag_ff;

endmodule

/* hw/rtl/fault_set_clear_qualifier.sv */
// Fault set/clear qualifier: a debounce counter table of
// BANK_COUNT * ENTRIES_PER_BANK entries, each with a set counter, a clear
// counter and a qualified flag.
// Request: drive req_bank, req_fault_index, req_func (0 set attempt,
// 1 clear attempt) and req_delay_count with start high; the poll is
// transferred at the clock edge where start is high and busy is low.
// Response: rsp_strobe is high for exactly one cycle with rsp_fault_flag,
// the entry's flag after the poll; the receiver cannot hold it off.
// Out-of-range bank or index changes nothing and returns a zero flag.
// Sequence: the poll is captured at the request edge, the entry is read
// into a register, then the updated entry is written back and the strobe
// registered. No new poll is taken during this read-modify-write of the
// single-port table; busy drops in the strobe cycle, so the next poll
// can go in then.
// Reset: synchronous, active high. After reset a clearing pass writes one
// zero entry per cycle to each of the BANK_COUNT * ENTRIES_PER_BANK entries
// (32 by default), with busy held high.
`include "fault_set_clear_qualifier_assert.svh"

module fault_set_clear_qualifier #(
   parameter int ENTRIES_PER_BANK = 16,
   parameter int BANK_COUNT       = 2,
   parameter int COUNT_BITS       = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [fsq_pkg::BANK_W-1:0]      req_bank,
   input  logic [fsq_pkg::INDEX_W-1:0]     req_fault_index,
   input  logic                            req_func,
   input  logic [fsq_pkg::DELAY_W-1:0]     req_delay_count,
   output logic                            rsp_strobe,
   output logic                            rsp_fault_flag
);

   fsq_pkg::cmd_type    cmd;
   fsq_pkg::status_type status;

   fsq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   fsq_datapath #(
      .ENTRIES_PER_BANK (ENTRIES_PER_BANK),
      .BANK_COUNT       (BANK_COUNT),
      .COUNT_BITS       (COUNT_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_bank        (req_bank),
      .req_fault_index (req_fault_index),
      .req_func        (req_func),
      .req_delay_count (req_delay_count),
      .rsp_strobe      (rsp_strobe),
      .rsp_fault_flag  (rsp_fault_flag)
   );

   `FSQ_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `FSQ_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe)
   `FSQ_ASSERT_NOW(a_strobe_after_update, clock, reset, rsp_strobe, $past(cmd.update))
   `FSQ_ASSERT_NOW(a_no_work_while_clearing, clock, reset, cmd.clear, !cmd.capture && !cmd.update)

endmodule

/* test/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES    = 16;
   localparam int BANKS      = 2;
   localparam int COUNT_BITS = 16;
   localparam int DEPTH      = ENTRIES * BANKS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic FUNC_SET   = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   localparam int RANDOM_POLLS = 400;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int MAX_PRINTS   = 100;

   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      logic [fsq_pkg::BANK_W-1:0]  bank;
      logic [fsq_pkg::INDEX_W-1:0] index;
      logic                        func;
      logic [fsq_pkg::DELAY_W-1:0] delay;
      logic                        has_flag;
      logic                        flag;
   } poll_type;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [fsq_pkg::BANK_W-1:0]  req_bank;
   logic [fsq_pkg::INDEX_W-1:0] req_fault_index;
   logic                        req_func;
   logic [fsq_pkg::DELAY_W-1:0] req_delay_count;
   logic                        rsp_strobe;
   logic                        rsp_fault_flag;

   count_type set_count   [DEPTH];
   count_type clear_count [DEPTH];
   logic      qual_flag   [DEPTH];
   logic      pending_flags [$];

   logic poll_taken = 1'b0;
   int   cycle_count = 0;
   int   fail_count = 0;
   int   quiet_left = 0;

   // Flag expectations only where they follow directly from the debounce rule.
   poll_type directed_polls [0:18] = '{
      '{1'b0, 4'd0,  FUNC_SET,   16'd3,     1'b1, 1'b0},
      '{1'b0, 4'd0,  FUNC_SET,   16'd3,     1'b1, 1'b0},
      '{1'b0, 4'd0,  FUNC_SET,   16'd3,     1'b1, 1'b1},
      '{1'b0, 4'd0,  FUNC_SET,   16'd3,     1'b1, 1'b1},
      '{1'b0, 4'd0,  FUNC_CLEAR, 16'd0,     1'b1, 1'b0},
      '{1'b0, 4'd0,  FUNC_SET,   16'd1,     1'b1, 1'b1},
      '{1'b1, 4'd15, FUNC_SET,   16'd0,     1'b1, 1'b1},
      '{1'b1, 4'd15, FUNC_SET,   16'hFFFF,  1'b1, 1'b1},
      '{1'b1, 4'd15, FUNC_CLEAR, 16'hFFFF,  1'b1, 1'b1},
      '{1'b1, 4'd15, FUNC_CLEAR, 16'd1,     1'b0, 1'b0},
      '{1'b1, 4'd15, FUNC_SET,   16'hFFFF,  1'b0, 1'b0},
      '{1'b1, 4'd0,  FUNC_SET,   16'hAAAA,  1'b1, 1'b0},
      '{1'b0, 4'd15, FUNC_CLEAR, 16'h5555,  1'b1, 1'b0},
      '{1'b0, 4'd5,  FUNC_CLEAR, 16'd2,     1'b0, 1'b0},
      '{1'b0, 4'd5,  FUNC_CLEAR, 16'd2,     1'b0, 1'b0},
      '{1'b0, 4'd10, FUNC_SET,   16'd2,     1'b0, 1'b0},
      '{1'b0, 4'd10, FUNC_SET,   16'd1,     1'b0, 1'b0},
      '{1'b1, 4'd5,  FUNC_SET,   16'h8000,  1'b0, 1'b0},
      '{1'b1, 4'd10, FUNC_CLEAR, 16'h7FFF,  1'b0, 1'b0}
   };

   fault_set_clear_qualifier DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_bank        (req_bank),
      .req_fault_index (req_fault_index),
      .req_func        (req_func),
      .req_delay_count (req_delay_count),
      .rsp_strobe      (rsp_strobe),
      .rsp_fault_flag  (rsp_fault_flag)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report(input string msg);
      if (fail_count < MAX_PRINTS) begin
         $display("ERROR @%0t: %s", $time, msg);
      end
      fail_count++;
   endtask

   // Debounce one poll of one entry and return the entry's flag afterwards.
   function automatic logic poll_entry(input logic [fsq_pkg::BANK_W-1:0] bank,
                                       input logic [fsq_pkg::INDEX_W-1:0] index,
                                       input logic func,
                                       input logic [fsq_pkg::DELAY_W-1:0] delay);
      int unsigned entry;
      count_type   count;
      if (bank >= BANKS || index >= ENTRIES) begin
         return 1'b0;
      end
      entry = bank * ENTRIES + index;
      count = (func == FUNC_SET) ? set_count[entry] : clear_count[entry];
      if (count != COUNT_MAX) begin
         count = count + 1'b1;
      end
      if (count >= delay) begin
         count = (delay < COUNT_MAX) ? count_type'(delay) : COUNT_MAX;
         if (func == FUNC_SET) begin
            clear_count[entry] = '0;
            qual_flag[entry]   = 1'b1;
         end else begin
            set_count[entry] = '0;
            qual_flag[entry] = 1'b0;
         end
      end
      if (func == FUNC_SET) begin
         set_count[entry] = count;
      end else begin
         clear_count[entry] = count;
      end
      return qual_flag[entry];
   endfunction

   // Drive one poll from a falling edge and hold it until the transfer.
   task automatic send_poll(input poll_type p);
      logic predicted;
      req_bank        <= p.bank;
      req_fault_index <= p.index;
      req_func        <= p.func;
      req_delay_count <= p.delay;
      start           <= 1'b1;
      do @(negedge clock); while (!poll_taken);
      predicted = poll_entry(p.bank, p.index, p.func, p.delay);
      pending_flags.push_back(p.has_flag ? p.flag : predicted);
   endtask

   task automatic pause();
      int unsigned gap;
      int unsigned pick;
      if (quiet_left > 0) begin
         quiet_left--;
         gap = 0;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            quiet_left = $urandom_range(10, 40);
            gap = 0;
         end else if (pick < 65) begin
            gap = 0;
         end else if (pick < 90) begin
            gap = $urandom_range(1, 3);
         end else begin
            gap = $urandom_range(5, 40);
         end
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic random_polls(input int unsigned total);
      int unsigned sent;
      int unsigned run;
      poll_type    p;
      sent = 0;
      while (sent < total) begin
         p.bank     = fsq_pkg::BANK_W'($urandom_range(0, 1));
         p.index    = fsq_pkg::INDEX_W'($urandom_range(0, 15));
         p.func     = 1'($urandom_range(0, 1));
         p.has_flag = 1'b0;
         p.flag     = 1'b0;
         if ($urandom_range(0, 3) != 0) begin
            // Poll one entry often enough to qualify, mostly in one direction.
            p.delay = fsq_pkg::DELAY_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 40)
                                                                  : $urandom_range(0, 5));
            run = p.delay + 1 + $urandom_range(0, 2);
            repeat (run) begin
               if ($urandom_range(0, 9) == 0) begin
                  p.func = ~p.func;
               end
               send_poll(p);
               sent++;
               pause();
            end
         end else begin
            p.delay = fsq_pkg::DELAY_W'($urandom_range(0, 65535));
            send_poll(p);
            sent++;
            pause();
         end
      end
   endtask

   always @(posedge clock) begin
      logic want;
      cycle_count <= cycle_count + 1;
      poll_taken  <= !reset && start && !busy;
      if (!reset && rsp_strobe) begin
         if (pending_flags.size() == 0) begin
            report("fault flag strobed with no poll outstanding");
         end else begin
            want = pending_flags.pop_front();
            if (rsp_fault_flag !== want) begin
               report($sformatf("fault_flag %b, expected %b", rsp_fault_flag, want));
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         set_count[i]   = '0;
         clear_count[i] = '0;
         qual_flag[i]   = 1'b0;
      end
      reset           = 1'b1;
      start           = 1'b0;
      req_bank        = '0;
      req_fault_index = '0;
      req_func        = FUNC_SET;
      req_delay_count = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_polls[i]) begin
         send_poll(directed_polls[i]);
         pause();
      end

      random_polls(RANDOM_POLLS);

      start <= 1'b0;
      while (pending_flags.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
